[hdl/assert_macros.svh]
// Assertion macros included by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hdl/sqlx_pkg.sv]
// Package: token classes, lexer modes and keyword table for the SQL lexer
package sqlx_pkg;
    localparam int KEYWORD_LIMIT_DEF   = 32;
    localparam int LONGEST_KEYWORD_DEF = 10;
    localparam int LENGTH_BITS_DEF     = 16;
    localparam int KW_COUNT = 53;
    localparam int KW_SLOT  = 11;
    localparam int MAX_RES  = 4;
    localparam logic [7:0] HIGH_BIT = 8'h80;
    localparam logic [7:0] CASE_GAP = 8'd32;

    typedef logic [6:0] t_class;
    typedef logic [4:0] t_mode;

    localparam t_class C_SPACE = 7'd0, C_COMMENT = 7'd1, C_ILLEGAL = 7'd2, C_MINUS = 7'd3,
        C_LP = 7'd4, C_RP = 7'd5, C_SEMI = 7'd6, C_PLUS = 7'd7, C_STAR = 7'd8,
        C_EQ = 7'd9, C_LE = 7'd10, C_NE = 7'd11, C_LT = 7'd12, C_GE = 7'd13,
        C_GT = 7'd14, C_COMMA = 7'd15, C_STRING = 7'd16, C_INTEGER = 7'd17,
        C_DOUBLE = 7'd18, C_NAME = 7'd19, C_BLOB = 7'd20, C_KEYWORD0 = 7'd21;

    localparam t_mode M_IDLE = 5'd0, M_SPACE = 5'd1, M_COMMENT = 5'd2, M_MINUS = 5'd3,
        M_EQ = 5'd4, M_LT = 5'd5, M_GT = 5'd6, M_BANG = 5'd7, M_STR = 5'd8,
        M_STRQ = 5'd9, M_INT = 5'd10, M_INT_DOT = 5'd11, M_INT_E = 5'd12,
        M_INT_ES = 5'd13, M_FRAC = 5'd14, M_FRAC_E = 5'd15, M_FRAC_ES = 5'd16,
        M_EXP = 5'd17, M_BRACKET = 5'd18, M_IDENT = 5'd19, M_BLOB = 5'd20;

    // Keyword text, padded with zero bytes, first character in the top byte
    typedef logic [8*(KW_SLOT-1)-1:0] t_kw;
    localparam t_kw KW_TEXT [KW_COUNT] = '{
        {"AND",56'd0}, {"AS",64'd0}, {"DROP",48'd0}, {"FROM",48'd0},
        {"INSERT",32'd0}, {"INTO",48'd0}, {"IS",64'd0}, {"NOT",56'd0},
        {"NULL",48'd0}, {"SELECT",32'd0}, {"TABLE",40'd0}, {"VALUES",32'd0},
        {"WHERE",40'd0}, {"CREATE",32'd0}, {"GROUP",40'd0}, {"BY",64'd0},
        {"LIKE",48'd0}, {"ADD",56'd0}, {"USER",48'd0}, {"IDENTIFIED"},
        {"ROLE",48'd0}, {"SET",56'd0}, {"PASSWORD",16'd0}, {"FOR",56'd0},
        {"AVG",56'd0}, {"COUNT",40'd0}, {"LAST",48'd0}, {"MAX",56'd0},
        {"MIN",56'd0}, {"SUM",56'd0}, {"FIRST",40'd0}, {"BOOL",48'd0},
        {"BIGINT",32'd0}, {"DATETIME",16'd0}, {"DOUBLE",32'd0}, {"STRING",32'd0},
        {"BLOB",48'd0}, {"REAL2",40'd0}, {"REAL3",40'd0}, {"REAL4",40'd0},
        {"REAL6",40'd0}, {"ORDER",40'd0}, {"DESC",48'd0}, {"ASC",56'd0},
        {"ATTACH",32'd0}, {"DETACH",32'd0}, {"IN",64'd0}, {"LIMIT",40'd0},
        {"TRUE",48'd0}, {"FALSE",40'd0}, {"DATAFILE",16'd0}, {"DELETE",32'd0},
        {"TOP",56'd0}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3,4'd2,4'd4,4'd4,4'd6,4'd4,4'd2,4'd3,4'd4,4'd6,4'd5,4'd6,4'd5,4'd6,
        4'd5,4'd2,4'd4,4'd3,4'd4,4'd10,4'd4,4'd3,4'd8,4'd3,4'd3,4'd5,4'd4,4'd3,
        4'd3,4'd3,4'd5,4'd4,4'd6,4'd8,4'd6,4'd6,4'd4,4'd5,4'd5,4'd5,4'd5,4'd5,
        4'd4,4'd3,4'd6,4'd6,4'd2,4'd5,4'd4,4'd5,4'd8,4'd6,4'd3
    };

    // One result word inside the lexer, before length truncation
    typedef struct packed {
        t_class      cls;
        logic [31:0] len;
        logic        dq;
    } t_tok;

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction
    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction
    function automatic logic is_word(input logic [7:0] b);
        return (b & HIGH_BIT) != 8'd0 || is_digit(b) || b == "_" ||
               (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction
    function automatic logic [7:0] to_upper(input logic [7:0] b);
        return (b >= "a" && b <= "z") ? b - CASE_GAP : b;
    endfunction
endpackage

[hdl/sql_lexer.sv]
// Top level: byte stream in, token stream out
//
// SQL lexer. One byte of text enters per s_axis word (tdata = data_byte,
// tlast = last_byte); tokens leave on m_axis, one per word, with
// tdata = {doubled_quote, token_length} zero-padded to whole bytes,
// tuser = token_class, and tlast marking the final token caused by the input byte.
// A byte is lexed in the cycle it is accepted; its tokens (zero to four)
// are written into an output queue, which drives m_axis. A byte that
// yields zero or one token keeps one byte per cycle of throughput while
// m_axis_tready stays high; a byte that yields several tokens sends them
// one per m_axis word, and s_axis_tready drops while the queue cannot take a
// full batch. The rate is set by the lexer pass, done in the cycle a byte is
// accepted, and the output queue of eight words.
// A zero byte or tlast flushes all pending tokens.
// Reset (synchronous, active low) returns the lexer to idle and empties
// the queue. When m_axis_tready is low the token on m_axis holds.
module sql_lexer
    import sqlx_pkg::*;
#(
    parameter int KEYWORD_LIMIT   = KEYWORD_LIMIT_DEF,
    parameter int LONGEST_KEYWORD = LONGEST_KEYWORD_DEF,
    parameter int LENGTH_BITS     = LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // data_byte
    input  logic                   s_axis_tlast,   // last_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [8*((LENGTH_BITS+8)/8)-1:0] m_axis_tdata, // token_length, doubled_quote
    output logic [6:0]             m_axis_tuser,   // token_class
    output logic                   m_axis_tlast    // last_token
);
`include "assert_macros.svh"
    localparam int TDATA_W = 8 * ((LENGTH_BITS + 8) / 8);

    typedef struct packed {
        t_class                 cls;
        logic [LENGTH_BITS-1:0] len;
        logic                   dq;
        logic                   last;
    } t_out;

    t_tok [MAX_RES-1:0] w_tok;
    logic [2:0]         w_cnt;
    logic               w_acc;
    t_out               r_q [8];
    logic [2:0]         r_rd, r_wr;
    logic [3:0]         r_fill;
    logic               w_pop;

    sqlx_core #(
        .KEYWORD_LIMIT(KEYWORD_LIMIT), .LONGEST_KEYWORD(LONGEST_KEYWORD),
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_acc), .i_byte(s_axis_tdata),
        .i_last(s_axis_tlast), .o_tok(w_tok), .o_cnt(w_cnt)
    );

    assign s_axis_tready = r_fill <= 4'd4;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_pop = m_axis_tvalid && m_axis_tready;

    // Output queue: the words of a batch of up to four are all written in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_fill <= '0;
        end else begin
            r_rd <= r_rd + 3'(w_pop);
            r_wr <= r_wr + (w_acc ? w_cnt : 3'd0);
            r_fill <= r_fill + 4'(w_acc ? w_cnt : 3'd0) - 4'(w_pop);
        end
    end
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (w_acc && 3'(i) < w_cnt)
                r_q[r_wr + 3'(i)] <= '{w_tok[i].cls, LENGTH_BITS'(w_tok[i].len),
                                      w_tok[i].dq, 3'(i + 1) == w_cnt};
        end
    end

    assign m_axis_tvalid = r_fill != 4'd0;
    assign m_axis_tuser  = r_q[r_rd].cls;
    assign m_axis_tdata  = TDATA_W'({r_q[r_rd].dq, r_q[r_rd].len});
    assign m_axis_tlast  = r_q[r_rd].last;

    `ASSERT_IMPL(a_fill_max, i_clk, i_rst_n, 1'b1, r_fill <= 4'd8)
    `ASSERT_IMPL(a_cnt_max, i_clk, i_rst_n, w_acc, w_cnt <= 3'd4)
    `ASSERT_NEXT(a_fill_grow, i_clk, i_rst_n, w_acc && w_cnt != 3'd0 && !w_pop,
                 r_fill != 4'd0)
endmodule

[hdl/sqlx_kw_match.sv]
// Keyword matcher: compares a word buffer against the keyword table
module sqlx_kw_match
    import sqlx_pkg::*;
#(
    parameter int KEYWORD_LIMIT   = KEYWORD_LIMIT_DEF,
    parameter int LONGEST_KEYWORD = LONGEST_KEYWORD_DEF,
    parameter int LENGTH_BITS     = LENGTH_BITS_DEF
) (
    input  logic [LONGEST_KEYWORD-1:0][7:0] i_word,
    input  logic [LENGTH_BITS-1:0]          i_count,
    output t_class                          o_class
);
    logic [8*(KW_SLOT-1)-1:0] w_txt;
    logic                     w_ok;

    // Only the first ten bytes can ever form a keyword
    always_comb begin
        w_txt = '0;
        for (int i = 0; i < KW_SLOT - 1; i++) begin
            if (i < LONGEST_KEYWORD && 32'(i) < 32'(i_count))
                w_txt[8*(KW_SLOT-2-i) +: 8] = i_word[i];
        end
        w_ok = i_count != '0 && 32'(i_count) < 32'(KEYWORD_LIMIT) &&
               32'(i_count) <= 32'(LONGEST_KEYWORD) && 32'(i_count) < 32'(KW_SLOT);
        o_class = C_NAME;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (w_ok && 32'(KW_LEN[k]) == 32'(i_count) && w_txt == KW_TEXT[k])
                o_class = C_KEYWORD0 + 7'(k);
        end
    end
endmodule

[hdl/sqlx_core.sv]
// Lexer core: one byte in, up to four tokens out, next state computed in one pass
module sqlx_core
    import sqlx_pkg::*;
#(
    parameter int KEYWORD_LIMIT   = KEYWORD_LIMIT_DEF,
    parameter int LONGEST_KEYWORD = LONGEST_KEYWORD_DEF,
    parameter int LENGTH_BITS     = LENGTH_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic [7:0]              i_byte,
    input  logic                    i_last,
    output t_tok [MAX_RES-1:0]      o_tok,
    output logic [2:0]              o_cnt
);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    logic [4:0]              r_mode, n_mode;
    logic [LENGTH_BITS-1:0]  r_count, n_count;
    logic [7:0]              r_quote, n_quote;
    logic [LONGEST_KEYWORD-1:0][7:0] r_word, n_word;
    logic [1:0][7:0]         r_held, n_held;
    logic [1:0]              r_hcnt, n_hcnt;
    logic                    r_esc, n_esc, r_bad, n_bad;
    t_class                  w_kw;
    logic [LONGEST_KEYWORD-1:0][7:0] w_xword;
    logic [LENGTH_BITS-1:0]  w_xcount;
    t_class                  w_kwx;

    sqlx_kw_match #(
        .KEYWORD_LIMIT(KEYWORD_LIMIT), .LONGEST_KEYWORD(LONGEST_KEYWORD),
        .LENGTH_BITS(LENGTH_BITS)
    ) u_kw (.i_word(r_word), .i_count(r_count), .o_class(w_kw));

    // Stored word grown by the incoming byte, for a word closed by the end of statement
    always_comb begin
        w_xword = r_word;
        for (int j = 0; j < LONGEST_KEYWORD; j++)
            if (32'(r_count) == 32'(j)) w_xword[j] = to_upper(i_byte);
        w_xcount = (r_count == LEN_MAX) ? LEN_MAX : r_count + 1'b1;
    end

    sqlx_kw_match #(
        .KEYWORD_LIMIT(KEYWORD_LIMIT), .LONGEST_KEYWORD(LONGEST_KEYWORD),
        .LENGTH_BITS(LENGTH_BITS)
    ) u_kw_x (.i_word(w_xword), .i_count(w_xcount), .o_class(w_kwx));

    // Walk the byte (and any replayed held bytes) through the mode logic
    always_comb begin
        logic [4:0] m;
        logic [LENGTH_BITS-1:0] cnt;
        logic [7:0] q, b;
        logic [LONGEST_KEYWORD-1:0][7:0] wb;
        logic [1:0][7:0] hb;
        logic [1:0] hc;
        logic es, bd, done, again, replay, kwv, kwx;
        logic [7:0] qb [4];
        int qn, qi;
        t_class kwc, kwe;
        t_class ncls;
        logic [32:0] sum;
        m = r_mode; cnt = r_count; q = r_quote; wb = r_word; hb = r_held;
        hc = r_hcnt; es = r_esc; bd = r_bad;
        o_tok = '0; o_cnt = 3'd0;
        kwv = 1'b1; kwx = 1'b0; kwc = w_kw; kwe = w_kwx;
        b = 8'd0; done = 1'b0; again = 1'b0; replay = 1'b0; ncls = C_SPACE; sum = '0;
        qb[0] = i_byte; qb[1] = 8'd0; qb[2] = 8'd0; qb[3] = 8'd0;
        qn = (i_byte == 8'd0) ? 0 : 1;
        qi = 0;
        // At most a few passes: the byte, replays and the flush
        for (int g = 0; g < 8; g++) begin
            if (qi < qn) begin
                b = qb[qi];
                done = 1'b1; again = 1'b0; replay = 1'b0;
                ncls = C_SPACE;
                case (m)
                    M_IDLE: begin
                        cnt = LENGTH_BITS'(1);
                        m = M_IDLE;
                        if (b == " " || b == 8'd9 || b == 8'd10 || b == 8'd12 || b == 8'd13)
                            m = M_SPACE;
                        else if (b == "-") m = M_MINUS;
                        else if (b == "=") m = M_EQ;
                        else if (b == "<") m = M_LT;
                        else if (b == ">") m = M_GT;
                        else if (b == "!") m = M_BANG;
                        else if (b == "'" || b == "\"") begin
                            m = M_STR; q = b; es = 1'b0;
                        end else if (b == "[") m = M_BRACKET;
                        else if (is_digit(b)) m = M_INT;
                        else if (is_word(b)) begin
                            m = M_IDENT; wb[0] = to_upper(b); kwv = 1'b0;
                        end else begin
                            case (b)
                                "(": ncls = C_LP;
                                ")": ncls = C_RP;
                                ";": ncls = C_SEMI;
                                "+": ncls = C_PLUS;
                                "*": ncls = C_STAR;
                                ",": ncls = C_COMMA;
                                default: ncls = C_ILLEGAL;
                            endcase
                            o_tok[o_cnt[1:0]] = '{ncls, 32'd1, 1'b0};
                            o_cnt = o_cnt + 3'd1;
                        end
                    end
                    M_SPACE:
                        if ((b >= 8'd9 && b <= 8'd13) || b == " ") begin
                            if (cnt != LEN_MAX) cnt = cnt + 1'b1;
                        end else begin
                            o_tok[o_cnt[1:0]] = '{C_SPACE, 32'(cnt), 1'b0};
                            o_cnt = o_cnt + 3'd1; again = 1'b1;
                        end
                    M_COMMENT:
                        if (b != 8'd10) begin
                            if (cnt != LEN_MAX) cnt = cnt + 1'b1;
                        end else begin
                            o_tok[o_cnt[1:0]] = '{C_COMMENT, 32'(cnt), 1'b0};
                            o_cnt = o_cnt + 3'd1; again = 1'b1;
                        end
                    M_MINUS:
                        if (b == "-") begin
                            m = M_COMMENT; cnt = LENGTH_BITS'(2);
                        end else begin
                            o_tok[o_cnt[1:0]] = '{C_MINUS, 32'd1, 1'b0};
                            o_cnt = o_cnt + 3'd1; again = 1'b1;
                        end
                    M_EQ, M_GT, M_BANG, M_LT: begin
                        if (b == "=" || (m == M_LT && b == ">")) begin
                            ncls = (m == M_EQ) ? C_EQ : (m == M_GT) ? C_GE :
                                   (m == M_BANG || b == ">") ? C_NE : C_LE;
                            o_tok[o_cnt[1:0]] = '{ncls, 32'd2, 1'b0};
                            m = M_IDLE;
                        end else begin
                            ncls = (m == M_EQ) ? C_EQ : (m == M_GT) ? C_GT :
                                   (m == M_LT) ? C_LT : C_ILLEGAL;
                            o_tok[o_cnt[1:0]] = '{ncls, 32'd1, 1'b0};
                            again = 1'b1;
                        end
                        o_cnt = o_cnt + 3'd1;
                    end
                    M_STR: begin
                        if (cnt != LEN_MAX) cnt = cnt + 1'b1;
                        if (b == q) m = M_STRQ;
                    end
                    M_STRQ:
                        if (b == q) begin
                            if (cnt != LEN_MAX) cnt = cnt + 1'b1;
                            es = 1'b1; m = M_STR;
                        end else begin
                            o_tok[o_cnt[1:0]] = '{C_STRING, 32'(cnt), es};
                            o_cnt = o_cnt + 3'd1; again = 1'b1;
                        end
                    M_INT, M_FRAC, M_EXP:
                        if (is_digit(b)) begin
                            if (cnt != LEN_MAX) cnt = cnt + 1'b1;
                        end else if (m == M_INT && b == ".") begin
                            hb[hc[0]] = b; hc = hc + 2'd1; m = M_INT_DOT;
                        end else if (m != M_EXP && (b == "e" || b == "E")) begin
                            hb[hc[0]] = b; hc = hc + 2'd1;
                            m = (m == M_INT) ? M_INT_E : M_FRAC_E;
                        end else begin
                            ncls = (m == M_INT) ? C_INTEGER : C_DOUBLE;
                            o_tok[o_cnt[1:0]] = '{ncls, 32'(cnt), 1'b0};
                            o_cnt = o_cnt + 3'd1; again = 1'b1;
                        end
                    M_INT_DOT, M_INT_E, M_FRAC_E, M_INT_ES, M_FRAC_ES:
                        if (is_digit(b)) begin
                            sum = 33'(cnt) + 33'(hc) + 33'd1;
                            cnt = (sum > 33'(LEN_MAX)) ? LEN_MAX : LENGTH_BITS'(sum);
                            hc = 2'd0;
                            m = (m == M_INT_DOT) ? M_FRAC : M_EXP;
                        end else if ((m == M_INT_E || m == M_FRAC_E) &&
                                     (b == "+" || b == "-")) begin
                            if (hc < 2'd2) begin
                                hb[hc[0]] = b; hc = hc + 2'd1;
                            end
                            m = (m == M_INT_E) ? M_INT_ES : M_FRAC_ES;
                        end else begin
                            ncls = (m == M_INT_DOT || m == M_INT_E || m == M_INT_ES) ?
                                   C_INTEGER : C_DOUBLE;
                            o_tok[o_cnt[1:0]] = '{ncls, 32'(cnt), 1'b0};
                            o_cnt = o_cnt + 3'd1; replay = 1'b1;
                        end
                    M_BRACKET: begin
                        if (cnt != LEN_MAX) cnt = cnt + 1'b1;
                        if (b == "]") begin
                            o_tok[o_cnt[1:0]] = '{C_NAME, 32'(cnt), 1'b0};
                            o_cnt = o_cnt + 3'd1; m = M_IDLE;
                        end
                    end
                    M_IDENT:
                        if (cnt == LENGTH_BITS'(1) && wb[0] == "X" &&
                            (b == "'" || b == "\"")) begin
                            m = M_BLOB; q = b; cnt = LENGTH_BITS'(2); bd = 1'b0;
                        end else if (is_word(b) || b == ".") begin
                            for (int j = 0; j < LONGEST_KEYWORD; j++)
                                if (32'(cnt) == 32'(j)) wb[j] = to_upper(b);
                            if (cnt != LEN_MAX) cnt = cnt + 1'b1;
                            // Stored word grown by this byte: use the second matcher
                            if (kwv && !kwx) kwx = 1'b1;
                            else kwv = 1'b0;
                        end else begin
                            o_tok[o_cnt[1:0]] = '{kwv ? (kwx ? kwe : kwc) : C_NAME,
                                                  32'(cnt), 1'b0};
                            o_cnt = o_cnt + 3'd1; again = 1'b1;
                        end
                    M_BLOB:
                        if (b == q) begin
                            if (cnt != LEN_MAX) cnt = cnt + 1'b1;
                            o_tok[o_cnt[1:0]] = '{bd ? C_ILLEGAL : C_BLOB, 32'(cnt), 1'b0};
                            o_cnt = o_cnt + 3'd1; m = M_IDLE;
                        end else if (is_hex(b)) begin
                            if (cnt != LEN_MAX) cnt = cnt + 1'b1;
                            bd = ~bd;
                        end else begin
                            o_tok[o_cnt[1:0]] = '{C_ILLEGAL, 32'(cnt), 1'b0};
                            o_cnt = o_cnt + 3'd1; again = 1'b1;
                        end
                    default: again = 1'b1;
                endcase
                if (again) m = M_IDLE;
                else if (replay) begin
                    // Held suffix bytes go back in front of the current one
                    m = M_IDLE;
                    qb[3] = 8'd0;
                    if (hc == 2'd2) begin
                        qb[2] = b; qb[0] = hb[0]; qb[1] = hb[1]; qn = 3;
                    end else begin
                        qb[1] = b; qb[0] = hb[0]; qn = 2;
                    end
                    qi = 0; hc = 2'd0;
                end else qi = qi + 1;
                if (done && m == M_IDLE) begin
                    kwv = 1'b1; kwx = 1'b0;
                end
            end else if ((i_last || i_byte == 8'd0) && m != M_IDLE) begin
                // End of statement: flush the pending token
                qn = 0; qi = 0;
                case (m)
                    M_SPACE:   o_tok[o_cnt[1:0]] = '{C_SPACE, 32'(cnt), 1'b0};
                    M_COMMENT: o_tok[o_cnt[1:0]] = '{C_COMMENT, 32'(cnt), 1'b0};
                    M_MINUS:   o_tok[o_cnt[1:0]] = '{C_MINUS, 32'd1, 1'b0};
                    M_EQ:      o_tok[o_cnt[1:0]] = '{C_EQ, 32'd1, 1'b0};
                    M_LT:      o_tok[o_cnt[1:0]] = '{C_LT, 32'd1, 1'b0};
                    M_GT:      o_tok[o_cnt[1:0]] = '{C_GT, 32'd1, 1'b0};
                    M_BANG:    o_tok[o_cnt[1:0]] = '{C_ILLEGAL, 32'd1, 1'b0};
                    M_STR:     o_tok[o_cnt[1:0]] = '{C_ILLEGAL, 32'(cnt), 1'b0};
                    M_STRQ:    o_tok[o_cnt[1:0]] = '{C_STRING, 32'(cnt), es};
                    M_BRACKET: o_tok[o_cnt[1:0]] = '{C_NAME, 32'(cnt), 1'b0};
                    M_IDENT:   o_tok[o_cnt[1:0]] = '{kwv ? (kwx ? kwe : kwc) : C_NAME,
                                                     32'(cnt), 1'b0};
                    M_BLOB:    o_tok[o_cnt[1:0]] = '{C_BLOB, 32'(cnt), 1'b0};
                    default: begin
                        ncls = (m == M_INT || m == M_INT_DOT || m == M_INT_E ||
                                m == M_INT_ES) ? C_INTEGER : C_DOUBLE;
                        o_tok[o_cnt[1:0]] = '{ncls, 32'(cnt), 1'b0};
                        if (hc != 2'd0) begin
                            qb[0] = hb[0]; qb[1] = hb[1];
                            qn = (hc == 2'd2) ? 2 : 1;
                        end
                    end
                endcase
                o_cnt = o_cnt + 3'd1;
                hc = 2'd0; m = M_IDLE; kwv = 1'b1; kwx = 1'b0;
            end
        end
        if (o_cnt > 3'd4) o_cnt = 3'd4;
        n_mode = m; n_count = cnt; n_quote = q; n_word = wb; n_held = hb;
        n_hcnt = hc; n_esc = es; n_bad = bd;
    end

    // Lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_count <= '0; r_quote <= '0; r_held <= '0;
            r_hcnt <= '0; r_esc <= 1'b0; r_bad <= 1'b0;
        end else if (i_en) begin
            r_mode <= n_mode; r_count <= n_count; r_quote <= n_quote;
            r_held <= n_held; r_hcnt <= n_hcnt; r_esc <= n_esc; r_bad <= n_bad;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) r_word <= n_word;
    end
endmodule

[sim/tb_sql_lexer.sv]
// Self-checking testbench for the SQL lexer: byte stream in, predicted token stream compared
module tb_sql_lexer;
    import sqlx_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int RANDOM_BYTES = 450;
    localparam int LEN_TOP      = 65535;
    localparam int HOLD_CYCLES  = 300;
    localparam int NO_CLASS     = -1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data = 8'd0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_data;     // token_length, doubled_quote
    logic [6:0]  m_user;     // token_class
    logic        m_last;

    sql_lexer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last)
    );

    always #2 i_clk = ~i_clk;

    typedef struct {
        t_class      cls;
        logic [15:0] len;
        logic        dq;
        logic        lst;
    } tok_t;

    typedef struct {
        logic [7:0] b;
        logic       l;
        int         cls;
    } row_t;

    // Lexer state mirror
    t_mode       lx_mode;
    logic [15:0] tok_len;
    logic [7:0]  quote_ch;
    logic [7:0]  word_buf [10];
    logic [7:0]  held [2];
    int          held_n;
    logic        esc_seen;
    logic        blob_odd;

    tok_t tokens_due [$];
    tok_t batch [$];

    int errors = 0;
    int cycles = 0;
    int bytes_sent = 0;
    int tokens_seen = 0;
    int src_idle = 10;
    int snk_idle = 49;
    bit hold_off = 0;

    function automatic bit dig(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit hexd(input logic [7:0] b);
        return dig(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic bit wordc(input logic [7:0] b);
        return b[7] || dig(b) || b == "_" || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic [7:0] up(input logic [7:0] b);
        return (b >= "a" && b <= "z") ? b - 8'd32 : b;
    endfunction

    function automatic void emit(input t_class c, input logic [15:0] n, input logic dq);
        tok_t t;
        if (batch.size() < MAX_RES) begin
            t.cls = c; t.len = n; t.dq = dq; t.lst = 1'b0;
            batch.push_back(t);
        end
    endfunction

    function automatic void bump(input int n);
        if (LEN_TOP - int'(tok_len) < n) tok_len = 16'hFFFF;
        else tok_len = tok_len + n[15:0];
    endfunction

    function automatic void hold(input logic [7:0] b);
        if (held_n < 2) begin
            held[held_n] = b;
            held_n++;
        end
    endfunction

    // Keyword lookup on the upper-cased word prefix
    function automatic t_class word_class();
        int  n;
        bit  hit;
        n = tok_len;
        if (n == 0 || n >= 32 || n > 10) return C_NAME;
        for (int i = 0; i < KW_COUNT; i++) begin
            hit = (KW_LEN[i] == n);
            for (int j = 0; j < n; j++)
                if (word_buf[j] != KW_TEXT[i][79-8*j -: 8]) hit = 0;
            if (hit) return C_KEYWORD0 + i[6:0];
        end
        return C_NAME;
    endfunction

    function automatic t_class num_class();
        return (lx_mode == M_INT || lx_mode == M_INT_DOT || lx_mode == M_INT_E ||
                lx_mode == M_INT_ES) ? C_INTEGER : C_DOUBLE;
    endfunction

    function automatic void open_tok(input logic [7:0] b);
        tok_len = 1;
        lx_mode = M_IDLE;
        if (b == " " || b == 8'd9 || b == 8'd10 || b == 8'd12 || b == 8'd13) lx_mode = M_SPACE;
        else if (b == "-") lx_mode = M_MINUS;
        else if (b == "=") lx_mode = M_EQ;
        else if (b == "<") lx_mode = M_LT;
        else if (b == ">") lx_mode = M_GT;
        else if (b == "!") lx_mode = M_BANG;
        else if (b == "(") emit(C_LP, 1, 0);
        else if (b == ")") emit(C_RP, 1, 0);
        else if (b == ";") emit(C_SEMI, 1, 0);
        else if (b == "+") emit(C_PLUS, 1, 0);
        else if (b == "*") emit(C_STAR, 1, 0);
        else if (b == ",") emit(C_COMMA, 1, 0);
        else if (b == 8'h27 || b == 8'h22) begin
            lx_mode = M_STR; quote_ch = b; esc_seen = 0;
        end else if (b == "[") lx_mode = M_BRACKET;
        else if (dig(b)) lx_mode = M_INT;
        else if (wordc(b)) begin
            lx_mode = M_IDENT; word_buf[0] = up(b);
        end else emit(C_ILLEGAL, 1, 0);
    endfunction

    // 0: consumed, 1: relex byte from idle, 2: relex held suffix then byte
    function automatic int take(input logic [7:0] b);
        t_mode m;
        m = lx_mode;
        case (m)
            M_IDLE: begin
                open_tok(b);
                return 0;
            end
            M_SPACE: begin
                if ((b >= 8'd9 && b <= 8'd13) || b == " ") begin bump(1); return 0; end
                emit(C_SPACE, tok_len, 0);
            end
            M_COMMENT: begin
                if (b != 8'd10) begin bump(1); return 0; end
                emit(C_COMMENT, tok_len, 0);
            end
            M_MINUS: begin
                if (b == "-") begin lx_mode = M_COMMENT; tok_len = 2; return 0; end
                emit(C_MINUS, 1, 0);
            end
            M_EQ: begin
                if (b == "=") begin emit(C_EQ, 2, 0); lx_mode = M_IDLE; return 0; end
                emit(C_EQ, 1, 0);
            end
            M_LT: begin
                if (b == "=" || b == ">") begin
                    emit(b == "=" ? C_LE : C_NE, 2, 0); lx_mode = M_IDLE; return 0;
                end
                emit(C_LT, 1, 0);
            end
            M_GT: begin
                if (b == "=") begin emit(C_GE, 2, 0); lx_mode = M_IDLE; return 0; end
                emit(C_GT, 1, 0);
            end
            M_BANG: begin
                if (b == "=") begin emit(C_NE, 2, 0); lx_mode = M_IDLE; return 0; end
                emit(C_ILLEGAL, 1, 0);
            end
            M_STR: begin
                bump(1);
                if (b == quote_ch) lx_mode = M_STRQ;
                return 0;
            end
            M_STRQ: begin
                if (b == quote_ch) begin
                    bump(1); esc_seen = 1; lx_mode = M_STR; return 0;
                end
                emit(C_STRING, tok_len, esc_seen);
            end
            M_INT, M_FRAC, M_EXP: begin
                if (dig(b)) begin bump(1); return 0; end
                if (m == M_INT && b == ".") begin hold(b); lx_mode = M_INT_DOT; return 0; end
                if (m != M_EXP && (b == "e" || b == "E")) begin
                    hold(b); lx_mode = (m == M_INT) ? M_INT_E : M_FRAC_E; return 0;
                end
                emit(num_class(), tok_len, 0);
            end
            M_INT_DOT, M_INT_E, M_FRAC_E, M_INT_ES, M_FRAC_ES: begin
                if (dig(b)) begin
                    bump(held_n + 1); held_n = 0;
                    lx_mode = (m == M_INT_DOT) ? M_FRAC : M_EXP;
                    return 0;
                end
                if ((m == M_INT_E || m == M_FRAC_E) && (b == "+" || b == "-")) begin
                    hold(b); lx_mode = (m == M_INT_E) ? M_INT_ES : M_FRAC_ES; return 0;
                end
                emit(num_class(), tok_len, 0);
                lx_mode = M_IDLE;
                return 2;
            end
            M_BRACKET: begin
                bump(1);
                if (b == "]") begin emit(C_NAME, tok_len, 0); lx_mode = M_IDLE; end
                return 0;
            end
            M_IDENT: begin
                if (tok_len == 1 && word_buf[0] == "X" && (b == 8'h27 || b == 8'h22)) begin
                    lx_mode = M_BLOB; quote_ch = b; tok_len = 2; blob_odd = 0; return 0;
                end
                if (wordc(b) || b == ".") begin
                    if (tok_len < 10) word_buf[tok_len] = up(b);
                    bump(1); return 0;
                end
                emit(word_class(), tok_len, 0);
            end
            M_BLOB: begin
                if (b == quote_ch) begin
                    bump(1); emit(blob_odd ? C_ILLEGAL : C_BLOB, tok_len, 0);
                    lx_mode = M_IDLE; return 0;
                end
                if (hexd(b)) begin bump(1); blob_odd = ~blob_odd; return 0; end
                emit(C_ILLEGAL, tok_len, 0);
            end
            default: ;
        endcase
        lx_mode = M_IDLE;
        return 1;
    endfunction

    // Lex a short byte queue, replaying a held number suffix when it is refused
    function automatic void relex(input logic [7:0] q0 [4], input int n0);
        logic [7:0] q [4];
        logic [7:0] t [4];
        int i, n, k, r;
        q = q0; n = n0; i = 0;
        for (int g = 0; g < 32 && i < n; g++) begin
            r = take(q[i]);
            if (r == 0) i++;
            else if (r == 2) begin
                k = 0;
                for (int j = 0; j < held_n && j < 2; j++) begin t[k] = held[j]; k++; end
                for (int j = i; j < n && k < 4; j++) begin t[k] = q[j]; k++; end
                held_n = 0;
                q = t; n = k; i = 0;
            end
        end
    endfunction

    // End of statement: close every pending token
    function automatic void close_all();
        logic [7:0] q [4];
        int n;
        for (int g = 0; g < 8 && lx_mode != M_IDLE; g++) begin
            n = 0;
            case (lx_mode)
                M_SPACE:   emit(C_SPACE, tok_len, 0);
                M_COMMENT: emit(C_COMMENT, tok_len, 0);
                M_MINUS:   emit(C_MINUS, 1, 0);
                M_EQ:      emit(C_EQ, 1, 0);
                M_LT:      emit(C_LT, 1, 0);
                M_GT:      emit(C_GT, 1, 0);
                M_BANG:    emit(C_ILLEGAL, 1, 0);
                M_STR:     emit(C_ILLEGAL, tok_len, 0);
                M_STRQ:    emit(C_STRING, tok_len, esc_seen);
                M_BRACKET: emit(C_NAME, tok_len, 0);
                M_IDENT:   emit(word_class(), tok_len, 0);
                M_BLOB:    emit(C_BLOB, tok_len, 0);
                default: begin
                    emit(num_class(), tok_len, 0);
                    for (int j = 0; j < held_n && j < 2; j++) begin q[n] = held[j]; n++; end
                end
            endcase
            held_n = 0;
            lx_mode = M_IDLE;
            if (n > 0) relex(q, n);
        end
        lx_mode = M_IDLE;
        held_n = 0;
    endfunction

    // Tokens caused by one accepted byte, queued for checking
    function automatic void lex_byte(input logic [7:0] b, input logic l);
        logic [7:0] q [4];
        batch.delete();
        if (b == 8'd0) close_all();
        else begin
            q[0] = b;
            relex(q, 1);
            if (l) close_all();
        end
        if (batch.size() > 0) batch[batch.size()-1].lst = 1'b1;
        foreach (batch[i]) tokens_due.push_back(batch[i]);
    endfunction

    // Offer one word, with random idle cycles before it
    task automatic send_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= l;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        lex_byte(b, l);
        bytes_sent++;
    endtask

    task automatic go_idle();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (tokens_due.size() != 0) @(posedge i_clk);
    endtask

    // Random statement text builder
    logic [7:0] text_q [$];

    function automatic void put(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = 8'($urandom_range(0, 25));
        return $urandom_range(0, 1) ? "a" + c : "A" + c;
    endfunction

    function automatic void put_digits(input int n);
        for (int i = 0; i < n; i++) text_q.push_back("0" + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void build_fragment();
        logic [7:0] c;
        int k, n;
        string ops [16];
        ops = '{"-", "(", ")", ";", "+", "*", ",", "=", "==", "<=", "<>", "<",
                ">=", ">", "!=", "!"};
        case ($urandom_range(0, 10))
            0, 1: begin
                k = $urandom_range(0, KW_COUNT - 1);
                for (int j = 0; j < KW_LEN[k]; j++) begin
                    c = KW_TEXT[k][79-8*j -: 8];
                    if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) c = c + 8'd32;
                    text_q.push_back(c);
                end
            end
            2: begin
                n = $urandom_range(1, 14);
                text_q.push_back($urandom_range(0, 5) == 0 ? "x" : rand_letter());
                for (int j = 1; j < n; j++) begin
                    case ($urandom_range(0, 5))
                        0: text_q.push_back("0" + 8'($urandom_range(0, 9)));
                        1: text_q.push_back("_");
                        2: text_q.push_back(8'($urandom_range(128, 255)));
                        3: text_q.push_back(".");
                        default: text_q.push_back(rand_letter());
                    endcase
                end
            end
            3: begin
                put_digits($urandom_range(1, 3));
                if ($urandom_range(0, 1)) begin
                    put(".");
                    put_digits($urandom_range(0, 2));
                end
                if ($urandom_range(0, 1)) begin
                    put($urandom_range(0, 1) ? "e" : "E");
                    if ($urandom_range(0, 1)) put($urandom_range(0, 1) ? "+" : "-");
                    put_digits($urandom_range(0, 2));
                end
            end
            4: begin
                c = $urandom_range(0, 1) ? 8'h27 : 8'h22;
                text_q.push_back(c);
                n = $urandom_range(0, 6);
                for (int j = 0; j < n; j++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        text_q.push_back(c); text_q.push_back(c);
                    end else text_q.push_back(8'($urandom_range(32, 126)));
                end
                text_q.push_back(c);
            end
            5: begin
                put("--");
                n = $urandom_range(0, 8);
                for (int j = 0; j < n; j++) text_q.push_back(8'($urandom_range(11, 255)));
                text_q.push_back(8'd10);
            end
            6: begin
                put("[");
                n = $urandom_range(0, 6);
                for (int j = 0; j < n; j++) text_q.push_back(rand_letter());
                put("]");
            end
            7: begin
                put($urandom_range(0, 1) ? "x" : "X");
                c = $urandom_range(0, 1) ? 8'h27 : 8'h22;
                text_q.push_back(c);
                n = $urandom_range(0, 5);
                for (int j = 0; j < n; j++) begin
                    k = $urandom_range(0, 15);
                    text_q.push_back(k < 10 ? "0" + 8'(k) : "a" + 8'(k - 10));
                end
                if ($urandom_range(0, 5) == 0) put("g");
                text_q.push_back(c);
            end
            8: put(ops[$urandom_range(0, 15)]);
            9: begin
                n = $urandom_range(1, 4);
                for (int j = 0; j < n; j++) text_q.push_back(8'($urandom_range(9, 13)));
                put(" ");
            end
            default: text_q.push_back(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 2) == 0) put(" ");
    endfunction

    // Directed rows: reset flush, extremes, operators, special cases
    row_t dir_rows [] = '{
        '{8'h00, 1'b0, NO_CLASS},
        '{"(",   1'b1, C_LP},
        '{8'hFF, 1'b1, C_NAME},
        '{"A",   1'b0, NO_CLASS},
        '{"s",   1'b1, C_KEYWORD0 + 1},
        '{"1",   1'b0, NO_CLASS},
        '{".",   1'b0, NO_CLASS},
        '{8'h00, 1'b0, C_ILLEGAL},
        '{"x",   1'b0, NO_CLASS},
        '{8'h27, 1'b1, C_BLOB},
        '{8'h22, 1'b1, C_ILLEGAL},
        '{"!",   1'b1, C_ILLEGAL},
        '{8'h0B, 1'b1, C_ILLEGAL},
        '{"1",   1'b0, NO_CLASS},
        '{"e",   1'b0, NO_CLASS},
        '{"+",   1'b0, NO_CLASS},
        '{"5",   1'b1, C_DOUBLE},
        '{"[",   1'b1, C_NAME},
        '{"<",   1'b0, NO_CLASS},
        '{">",   1'b0, C_NE},
        '{"1",   1'b0, NO_CLASS},
        '{"e",   1'b1, C_NAME}
    };

    // Result checker and run watchdog
    always @(posedge i_clk) begin
        tok_t t;
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
        if (i_rst_n && m_valid && m_ready) begin
            tokens_seen++;
            if (tokens_due.size() == 0) begin
                $error("token with none expected: class %0d length %0d", m_user, m_data[15:0]);
                errors++;
            end else begin
                t = tokens_due.pop_front();
                if (m_user !== t.cls) begin
                    $error("token_class expected %0d got %0d", t.cls, m_user); errors++;
                end
                if (m_data[15:0] !== t.len) begin
                    $error("token_length expected %0d got %0d", t.len, m_data[15:0]); errors++;
                end
                if (m_data[16] !== t.dq) begin
                    $error("doubled_quote expected %0d got %0d", t.dq, m_data[16]); errors++;
                end
                if (m_last !== t.lst) begin
                    $error("last_token expected %0d got %0d", t.lst, m_last); errors++;
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 0;
            end
            m_ready <= ($urandom_range(0, 99) >= snk_idle);
        end
    end

    initial begin
        int rand_bytes;
        logic [7:0] b;
        logic l;
        lx_mode = M_IDLE; tok_len = 0; quote_ch = 0; held_n = 0;
        esc_seen = 0; blob_odd = 0;
        foreach (word_buf[i]) word_buf[i] = 8'd0;
        held[0] = 8'd0; held[1] = 8'd0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part
        foreach (dir_rows[r]) begin
            send_byte(dir_rows[r].b, dir_rows[r].l);
            if (dir_rows[r].cls != NO_CLASS &&
                (batch.size() == 0 || int'(batch[batch.size()-1].cls) != dir_rows[r].cls)) begin
                $error("token_class expected %0d for directed row %0d", dir_rows[r].cls, r);
                errors++;
            end
        end
        go_idle();

        // Random statements over three idling phases
        rand_bytes = 0;
        hold_off = 1;
        while (rand_bytes < RANDOM_BYTES) begin
            if (rand_bytes >= 2 * RANDOM_BYTES / 3 && src_idle != 0) begin
                go_idle();
                src_idle = 0; snk_idle = 0;
            end else if (rand_bytes >= RANDOM_BYTES / 3 && src_idle == 10) begin
                go_idle();
                src_idle = 49; snk_idle = 10;
            end
            text_q.delete();
            for (int f = $urandom_range(1, 6); f > 0; f--) build_fragment();
            case ($urandom_range(0, 2))
                0: text_q.push_back(8'd0);
                1: text_q.push_back(";");
                default: ;
            endcase
            l = ($urandom_range(0, 1) == 1);
            foreach (text_q[i]) begin
                b = text_q[i];
                send_byte(b, (i == text_q.size() - 1) ? l : 1'b0);
                rand_bytes++;
            end
        end

        s_valid <= 1'b0;
        @(posedge i_clk);
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d bytes and checked %0d tokens: directed cases and",
                 bytes_sent, tokens_seen);
        $display("random statements under three stall patterns and a long output hold-off");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[sql_lexer.f]
+incdir+hdl
hdl/sqlx_pkg.sv
hdl/sqlx_kw_match.sv
hdl/sqlx_core.sv
hdl/sql_lexer.sv
sim/tb_sql_lexer.sv
